// File: rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// shared types and constants for the touch swipe gesture classifier
// ----------------------------------------------------------------------------
package tsg_pkg;

  // display-space coordinate, two's complement
  localparam int unsigned CoordW = 10;
  typedef logic signed [CoordW-1:0] coord_t;

  // configuration register widths
  localparam int unsigned ScreenW = 9;
  localparam int unsigned LimitW  = 9;
  localparam int unsigned IdleLimW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_ROTATION   = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_SCREEN_W   = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_SCREEN_H   = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_SWIPE_MIN  = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_TAP_LIMIT  = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_IDLE_LIMIT = 3'd6;

  // configuration reset values
  localparam logic [ScreenW-1:0]  SCREEN_RESET     = 9'd240;
  localparam logic [LimitW-1:0]   SWIPE_MIN_RESET  = 9'd40;
  localparam logic [LimitW-1:0]   TAP_LIMIT_RESET  = 9'd12;
  localparam logic [IdleLimW-1:0] IDLE_LIMIT_RESET = 16'd90;

  // rotation in quarter turns
  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_e;

  // gesture codes
  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_LEFT  = 3'd1,
    GEST_RIGHT = 3'd2,
    GEST_UP    = 3'd3,
    GEST_DOWN  = 3'd4,
    GEST_TAP   = 3'd5
  } gesture_e;

  // item kind carried in the input tuser bit
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

endpackage

// File: rtl/tsg_map.sv
// ----------------------------------------------------------------------------
// tsg_map
// maps a raw panel point into display space for one of four rotations
// ----------------------------------------------------------------------------
module tsg_map (
  input  logic [1:0]                   rotation_i,
  input  logic [tsg_pkg::ScreenW-1:0]  screen_w_i,
  input  logic [tsg_pkg::ScreenW-1:0]  screen_h_i,
  input  logic [7:0]                   raw_x_i,
  input  logic [7:0]                   raw_y_i,
  output tsg_pkg::coord_t              map_x_o,
  output tsg_pkg::coord_t              map_y_o
);
  import tsg_pkg::*;

  logic [CoordW-1:0] rx, ry, w_m1, h_m1, w_rx, w_ry, h_rx, h_ry;

  always_comb begin
    rx   = {2'b00, raw_x_i};
    ry   = {2'b00, raw_y_i};
    w_m1 = {1'b0, screen_w_i} - 10'd1;
    h_m1 = {1'b0, screen_h_i} - 10'd1;
    // true values fit the signed coordinate, so wrapping is harmless
    w_rx = w_m1 - rx;
    w_ry = w_m1 - ry;
    h_rx = h_m1 - rx;
    h_ry = h_m1 - ry;
    unique case (rotation_e'(rotation_i))
      ROT_90: begin
        map_x_o = coord_t'(ry);
        map_y_o = coord_t'(h_rx);
      end
      ROT_180: begin
        map_x_o = coord_t'(w_rx);
        map_y_o = coord_t'(h_ry);
      end
      ROT_270: begin
        map_x_o = coord_t'(w_ry);
        map_y_o = coord_t'(rx);
      end
      default: begin
        map_x_o = coord_t'(rx);
        map_y_o = coord_t'(ry);
      end
    endcase
  end

endmodule

// File: rtl/tsg_classify.sv
// ----------------------------------------------------------------------------
// tsg_classify
// classifies a finished press from its start and end points
// ----------------------------------------------------------------------------
module tsg_classify (
  input  tsg_pkg::coord_t             start_x_i,
  input  tsg_pkg::coord_t             start_y_i,
  input  tsg_pkg::coord_t             cur_x_i,
  input  tsg_pkg::coord_t             cur_y_i,
  input  logic [tsg_pkg::LimitW-1:0]  swipe_min_i,
  input  logic [tsg_pkg::LimitW-1:0]  tap_limit_i,
  output tsg_pkg::gesture_e           gesture_o,
  output logic [7:0]                  peak_o
);
  import tsg_pkg::*;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        ax_w, ay_w;
  logic [CoordW-1:0]      ax, ay, peak_full, swipe_min, tap_limit;

  always_comb begin
    dx = {cur_x_i[CoordW-1], cur_x_i} - {start_x_i[CoordW-1], start_x_i};
    dy = {cur_y_i[CoordW-1], cur_y_i} - {start_y_i[CoordW-1], start_y_i};
    ax_w = dx[CoordW] ? 11'(-dx) : 11'(dx);
    ay_w = dy[CoordW] ? 11'(-dy) : 11'(dy);
    // magnitudes stay below 1024
    ax = ax_w[CoordW-1:0];
    ay = ay_w[CoordW-1:0];
    swipe_min = {1'b0, swipe_min_i};
    tap_limit = {1'b0, tap_limit_i};
    peak_full = (ax > ay) ? ax : ay;
    peak_o    = peak_full[7:0];

    if (ax >= swipe_min && ax > ay) begin
      gesture_o = dx[CoordW] ? GEST_LEFT : GEST_RIGHT;
    end else if (ay >= swipe_min && ay > ax) begin
      gesture_o = dy[CoordW] ? GEST_UP : GEST_DOWN;
    end else if (ax < tap_limit && ay < tap_limit) begin
      gesture_o = GEST_TAP;
    end else begin
      gesture_o = GEST_NONE;
    end
  end

endmodule

// File: rtl/touch_swipe_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier
// turns ticks and touch polls into swipe and tap gestures
// ----------------------------------------------------------------------------
// path: an input word is taken into the input register, then press logic writes its
//   result word into the result register; a stalled sink holds the word in the input register
// throughput: one word per cycle while the sink accepts results; the press state updates in a single pass
// reset: rst_ni clears press state, idle count, peak and valid flags at once,
//   and loads the register defaults; the block is ready right after reset
// ----------------------------------------------------------------------------
module touch_swipe_gesture_classifier #(
  parameter int unsigned IDLE_COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tsg_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [tsg_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // int_active, point_valid, raw_x[9:2],
                                                         // raw_y[17:10], zero pad
  input  logic                            s_axis_tuser,  // action: 0 tick, 1 poll
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata   // gesture[2:0], touch_down[3],
                                                         // touch_x[12:4], touch_y[21:13],
                                                         // peak_displacement[29:22], zero pad
);
  import tsg_pkg::*;

  // width used to compare the idle count against the limit register
  localparam int unsigned CmpW = (IDLE_COUNT_BITS > IdleLimW) ? IDLE_COUNT_BITS : IdleLimW;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                 enabled_q;
  logic [1:0]           rotation_q;
  logic [ScreenW-1:0]   screen_w_q, screen_h_q;
  logic [LimitW-1:0]    swipe_min_q, tap_limit_q;
  logic [IdleLimW-1:0]  idle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      rotation_q   <= ROT_0;
      screen_w_q   <= SCREEN_RESET;
      screen_h_q   <= SCREEN_RESET;
      swipe_min_q  <= SWIPE_MIN_RESET;
      tap_limit_q  <= TAP_LIMIT_RESET;
      idle_limit_q <= IDLE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLED:    enabled_q    <= cfg_wdata_i[0];
        CFG_ROTATION:   rotation_q   <= cfg_wdata_i[1:0];
        CFG_SCREEN_W:   screen_w_q   <= cfg_wdata_i[ScreenW-1:0];
        CFG_SCREEN_H:   screen_h_q   <= cfg_wdata_i[ScreenW-1:0];
        CFG_SWIPE_MIN:  swipe_min_q  <= cfg_wdata_i[LimitW-1:0];
        CFG_TAP_LIMIT:  tap_limit_q  <= cfg_wdata_i[LimitW-1:0];
        CFG_IDLE_LIMIT: idle_limit_q <= cfg_wdata_i[IdleLimW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input register feeds the result register
  // --------------------------------------------------------------------------
  logic in_vld_q, out_vld_q;
  logic in_take, advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || !out_vld_q || m_axis_tready;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input word register, payload only
  logic       act_q, int_q, pv_q;
  logic [7:0] raw_x_q, raw_y_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q   <= s_axis_tuser;
      int_q   <= s_axis_tdata[0];
      pv_q    <= s_axis_tdata[1];
      raw_x_q <= s_axis_tdata[9:2];
      raw_y_q <= s_axis_tdata[17:10];
    end
  end

  // --------------------------------------------------------------------------
  // press state
  // --------------------------------------------------------------------------
  logic                       tracking_q, tracking_d;
  coord_t                     start_x_q, start_x_d, start_y_q, start_y_d;
  coord_t                     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [IDLE_COUNT_BITS-1:0] idle_q, idle_d;
  logic [7:0]                 peak_q, peak_d;
  gesture_e                   gesture_d;

  coord_t     map_x, map_y;
  gesture_e   cls_gesture;
  logic [7:0] cls_peak;
  logic       idle_done;

  tsg_map u_map (
    .rotation_i (rotation_q),
    .screen_w_i (screen_w_q),
    .screen_h_i (screen_h_q),
    .raw_x_i    (raw_x_q),
    .raw_y_i    (raw_y_q),
    .map_x_o    (map_x),
    .map_y_o    (map_y)
  );

  tsg_classify u_classify (
    .start_x_i   (start_x_q),
    .start_y_i   (start_y_q),
    .cur_x_i     (cur_x_q),
    .cur_y_i     (cur_y_q),
    .swipe_min_i (swipe_min_q),
    .tap_limit_i (tap_limit_q),
    .gesture_o   (cls_gesture),
    .peak_o      (cls_peak)
  );

  assign idle_done = CmpW'(idle_q) >= CmpW'(idle_limit_q);

  always_comb begin
    tracking_d = tracking_q;
    start_x_d  = start_x_q;
    start_y_d  = start_y_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    idle_d     = idle_q;
    peak_d     = peak_q;
    gesture_d  = GEST_NONE;
    if (act_q == ACT_TICK) begin
      // idle count saturates at all ones
      if (idle_q != {IDLE_COUNT_BITS{1'b1}}) begin
        idle_d = idle_q + IDLE_COUNT_BITS'(1);
      end
    end else if (enabled_q) begin
      if (int_q) begin
        if (pv_q) begin
          if (!tracking_q) begin
            // first point of a new press
            tracking_d = 1'b1;
            start_x_d  = map_x;
            start_y_d  = map_y;
          end
          cur_x_d = map_x;
          cur_y_d = map_y;
          idle_d  = '0;
        end
      end else if (tracking_q && idle_done) begin
        // quiet poll after enough idle time ends the press
        tracking_d = 1'b0;
        gesture_d  = cls_gesture;
        peak_d     = cls_peak;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      idle_q     <= '0;
      peak_q     <= '0;
    end else if (advance) begin
      tracking_q <= tracking_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      idle_q     <= idle_d;
      peak_q     <= peak_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register, holds while the sink stalls
  // --------------------------------------------------------------------------
  gesture_e          res_gesture_q;
  logic              res_down_q;
  logic [8:0]        res_x_q, res_y_q;
  logic [7:0]        res_peak_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_gesture_q <= gesture_d;
      res_down_q    <= tracking_d;
      // coordinates read as zero when no press is tracked
      res_x_q       <= tracking_d ? cur_x_d[8:0] : 9'd0;
      res_y_q       <= tracking_d ? cur_y_d[8:0] : 9'd0;
      res_peak_q    <= peak_d;
    end
  end

  assign m_axis_tdata = {2'b00, res_peak_q, res_y_q, res_x_q, res_down_q, res_gesture_q};

endmodule
